// ===== hdl/kms_pkg.sv =====
// ----------------------------------------------------------------------------
// kms_pkg: shared constants and types for the key matrix scanner
// Matrix geometry, command codes and the debounce update bundle.
// ----------------------------------------------------------------------------
package kms_pkg;

  localparam int ROWS        = 8;
  localparam int COLS        = 9;
  localparam int KEYS        = ROWS * COLS;
  localparam int HIST_W      = 3;
  localparam int ROW_W       = 3;
  localparam int KEY_W       = 7;
  localparam int LED_W       = 8;
  localparam int CMD_COL_W   = 4;
  localparam int KEY_IN_W    = 9;
  localparam int LED_ROW_W   = (COLS > LED_W) ? COLS : LED_W;

  localparam logic [KEY_W-1:0]  NONE_CODE   = KEY_W'(KEYS - 1);
  localparam logic [7:0]        SPI_NOP     = 8'hFF;
  localparam logic [LED_W-1:0]  PHASE_START = LED_W'(8'h80);
  localparam logic [HIST_W-1:0] HIST_FULL   = '1;
  localparam logic [HIST_W-1:0] HIST_EMPTY  = '0;
  localparam logic [ROW_W-1:0]  ROW_START   = ROW_W'(1 % ROWS);

  typedef logic [HIST_W-1:0] hist_t;
  typedef hist_t [COLS-1:0]  hist_row_t;

  typedef struct packed {
    hist_row_t             hist;
    logic [COLS-1:0]       toggle;
    logic [KEY_W-1:0]      held;
    logic                  indicator;
    logic                  pending_set;
  } scan_upd_t;

endpackage

// ===== hdl/key_matrix_scanner_led_mux.sv =====
// ----------------------------------------------------------------------------
// key_matrix_scanner_led_mux: key matrix scan with debounce and LED multiplex
// Input channel (in_valid/in_ready) carries one word per scan tick (mode 0,
// key_bits of the current row) or per received SPI command byte (mode 1,
// spi_byte). Output channel (out_valid/out_ready) returns one word per input:
// row_select for the next sample, led_columns drive, indicator and spi_reply.
// The result is registered at the edge that accepts the input word. Throughput
// is one word per cycle while the receiver keeps out_ready high; the whole
// row update (nine column histories and the held key chain) is one
// combinational pass between the state registers and the result register.
// The input is accepted whenever the result register is empty or is being
// taken in the same cycle, so a stalled receiver holds off the sender after
// one word. Reset clears all key histories and LED bits, sets the held key
// to the none code, scan row to 1 and the column phase to its top bit.
// ----------------------------------------------------------------------------
module key_matrix_scanner_led_mux
  import kms_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                mode,
  input  logic [KEY_IN_W-1:0] key_bits,
  input  logic [7:0]          spi_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [ROW_W-1:0]    row_select,
  output logic [LED_W-1:0]    led_columns,
  output logic                indicator,
  output logic [7:0]          spi_reply
);

  hist_row_t              hist [ROWS];
  logic [LED_ROW_W-1:0]   led_rows [ROWS];
  logic [KEY_W-1:0]       held;
  logic                   pending;
  logic [ROW_W-1:0]       scan_row;
  logic [LED_W-1:0]       phase;
  logic                   ind_on;

  logic                   accept;
  scan_upd_t              upd;
  logic [LED_W-1:0]       phase_shift;
  logic                   phase_wrap;
  logic [ROW_W-1:0]       row_inc;
  logic [ROW_W-1:0]       cmd_row;
  logic [CMD_COL_W-1:0]   cmd_col;
  logic                   cmd_ok;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  kms_debounce u_debounce (
    .row       (scan_row),
    .key_bits  (key_bits),
    .hist_row  (hist[scan_row]),
    .held      (held),
    .indicator (ind_on),
    .upd       (upd)
  );

  assign phase_shift = phase >> 1;
  assign phase_wrap  = (phase_shift == '0);
  assign row_inc     = (32'(scan_row) == ROWS - 1) ? '0 : scan_row + ROW_W'(1);

  assign cmd_row = spi_byte[2:0];
  assign cmd_col = spi_byte[6:3];
  assign cmd_ok  = (spi_byte != SPI_NOP) && (32'(cmd_row) < ROWS) &&
                   (32'(cmd_col) < LED_W);

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < ROWS; r++) begin
        hist[r]     <= '0;
        led_rows[r] <= '0;
      end
      held     <= NONE_CODE;
      pending  <= 1'b0;
      scan_row <= ROW_START;
      phase    <= PHASE_START;
      ind_on   <= 1'b0;
    end else if (accept) begin
      if (!mode) begin
        hist[scan_row]     <= upd.hist;
        led_rows[scan_row] <= led_rows[scan_row] ^ LED_ROW_W'(upd.toggle);
        held               <= upd.held;
        ind_on             <= upd.indicator;
        if (upd.pending_set) begin
          pending <= 1'b1;
        end
        if (phase_wrap) begin
          phase    <= PHASE_START;
          scan_row <= row_inc;
        end else begin
          phase <= phase_shift;
        end
      end else begin
        pending <= 1'b0;
        if (cmd_ok) begin
          led_rows[cmd_row][cmd_col[2:0]] <= spi_byte[7];
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (!mode) begin
        row_select  <= phase_wrap ? row_inc : scan_row;
        led_columns <= phase & led_rows[scan_row][LED_W-1:0];
        indicator   <= upd.indicator;
        spi_reply   <= '0;
      end else begin
        row_select  <= scan_row;
        led_columns <= '0;
        indicator   <= ind_on;
        spi_reply   <= pending ? 8'(held) : 8'(NONE_CODE);
      end
    end
  end

endmodule

// ===== hdl/kms_debounce.sv =====
// ----------------------------------------------------------------------------
// kms_debounce: per-row press debounce and held key tracking
// Shifts one sample into each column history of the scanned row and works
// out the new held key, indicator and LED toggles in column order.
// ----------------------------------------------------------------------------
module kms_debounce
  import kms_pkg::*;
(
  input  logic [ROW_W-1:0]    row,
  input  logic [KEY_IN_W-1:0] key_bits,
  input  hist_row_t           hist_row,
  input  logic [KEY_W-1:0]    held,
  input  logic                indicator,
  output scan_upd_t           upd
);

  always_comb begin
    logic [KEY_W-1:0] base;
    logic [KEY_W-1:0] idx;
    logic [KEY_W-1:0] held_v;
    logic             ind_v;
    hist_t            h;
    base   = KEY_W'(32'(row) * COLS);
    held_v = held;
    ind_v  = indicator;
    upd    = '0;
    for (int c = 0; c < COLS; c++) begin
      h   = {hist_row[c][HIST_W-2:0], key_bits[c]};
      idx = base + KEY_W'(c);
      upd.hist[c] = h;
      if (idx != held_v && h == HIST_FULL) begin
        held_v          = idx;
        upd.pending_set = 1'b1;
        upd.toggle[c]   = ~upd.toggle[c];
        ind_v           = 1'b1;
      end
      // release: checked against the held key as updated so far
      if (idx == held_v && h == HIST_EMPTY) begin
        ind_v  = 1'b0;
        held_v = NONE_CODE;
      end
    end
    upd.held      = held_v;
    upd.indicator = ind_v;
  end

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: key matrix scanner with debounce and LED multiplex
// Drives scan ticks and SPI command words through the valid/ready input
// channel and tracks debounce history, held key, pending reply and LED rows in
// a scoreboard class. Every result word is checked field by field in order.
// Sender bursts, receiver stall patterns, a long receiver hold-off and a
// drain pause exercise the handshake. Key patterns are held over several
// ticks so that presses debounce, with noise mixed in.
// ----------------------------------------------------------------------------
module testbench;
  import kms_pkg::*;

  localparam logic MODE_SCAN   = 1'b0;
  localparam logic MODE_SPI    = 1'b1;
  localparam int   CYCLE_LIMIT = 200000;
  localparam int   RANDOM_WORDS = 900;
  localparam int   LONG_HOLD_AT = 400;
  localparam int   DRAIN_AT     = 600;

  typedef enum {RX_OPEN, RX_COIN, RX_MOSTLY, RX_PERIODIC} rx_style_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [LED_W-1:0] led;
    logic             ind;
    logic [7:0]       reply;
  } scan_result_t;

  class key_led_tracker;
    logic [HIST_W-1:0]    hist [KEYS];
    logic [KEY_W-1:0]     held;
    logic                 pending;
    logic [LED_ROW_W-1:0] leds [ROWS];
    logic [ROW_W-1:0]     row_now;
    logic [LED_W-1:0]     phase;
    logic                 ind_on;
    scan_result_t         due[$];
    int                   errors;

    function new();
      foreach (hist[i]) hist[i] = HIST_EMPTY;
      foreach (leds[i]) leds[i] = '0;
      held    = NONE_CODE;
      pending = 1'b0;
      row_now = ROW_START;
      phase   = PHASE_START;
      ind_on  = 1'b0;
      errors  = 0;
    endfunction

    function void note_word(logic m, logic [KEY_IN_W-1:0] k, logic [7:0] s);
      scan_result_t r;
      int idx, row, col;
      logic [HIST_W-1:0] h;
      if (m == MODE_SPI) begin
        r.reply = pending ? 8'(held) : 8'(NONE_CODE);
        pending = 1'b0;
        if (s != SPI_NOP) begin
          row = s[2:0];
          col = s[6:3];
          // column 8 and up cannot be set from SPI
          if (row < ROWS && col < LED_W) leds[row][col] = s[7];
        end
        r.row = row_now;
        r.led = '0;
        r.ind = ind_on;
      end else begin
        row   = row_now;
        r.led = phase & leds[row][LED_W-1:0];
        for (col = 0; col < COLS; col++) begin
          idx = row * COLS + col;
          h = {hist[idx][HIST_W-2:0], k[col]};
          hist[idx] = h;
          if (idx != int'(held) && h == HIST_FULL) begin
            held    = KEY_W'(idx);
            pending = 1'b1;
            leds[row][col] = ~leds[row][col];
            ind_on  = 1'b1;
          end
          if (idx == int'(held) && h == HIST_EMPTY) begin
            ind_on = 1'b0;
            held   = NONE_CODE;
          end
        end
        phase = phase >> 1;
        if (phase == '0) begin
          phase   = PHASE_START;
          row_now = (row == ROWS - 1) ? '0 : ROW_W'(row + 1);
        end
        r.row   = row_now;
        r.ind   = ind_on;
        r.reply = '0;
      end
      due.push_back(r);
    endfunction

    function void check_word(logic [ROW_W-1:0] row, logic [LED_W-1:0] led,
                             logic ind, logic [7:0] reply);
      scan_result_t e;
      if (due.size() == 0) begin
        $error("result word with no expectation waiting");
        errors++;
        return;
      end
      e = due.pop_front();
      if (row !== e.row) begin
        $error("row_select: expected %0d, actual %0d", e.row, row);
        errors++;
      end
      if (led !== e.led) begin
        $error("led_columns: expected %h, actual %h", e.led, led);
        errors++;
      end
      if (ind !== e.ind) begin
        $error("indicator: expected %b, actual %b", e.ind, ind);
        errors++;
      end
      if (reply !== e.reply) begin
        $error("spi_reply: expected %0d, actual %0d", e.reply, reply);
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic                mode;
  logic [KEY_IN_W-1:0] key_bits;
  logic [7:0]          spi_byte;
  logic                out_valid;
  logic                out_ready;
  logic [ROW_W-1:0]    row_select;
  logic [LED_W-1:0]    led_columns;
  logic                indicator;
  logic [7:0]          spi_reply;

  key_led_tracker tracker = new();
  int accepted = 0;
  int cycles = 0;

  key_matrix_scanner_led_mux dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .key_bits   (key_bits),
    .spi_byte   (spi_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .row_select (row_select),
    .led_columns(led_columns),
    .indicator  (indicator),
    .spi_reply  (spi_reply)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      tracker.check_word(row_select, led_columns, indicator, spi_reply);
  end

  // receiver: stall style changes every so often; one long hold-off mid-run
  initial begin
    rx_style_t style;
    int span, stall_left, tick;
    bit long_done;
    span = 0;
    stall_left = 0;
    tick = 0;
    long_done = 0;
    style = RX_OPEN;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (!long_done && accepted >= LONG_HOLD_AT) begin
        long_done = 1;
        stall_left = 200;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        if (span == 0) begin
          style = rx_style_t'($urandom_range(0, 3));
          span = $urandom_range(20, 120);
        end
        span--;
        case (style)
          RX_OPEN:     out_ready <= 1'b1;
          RX_COIN:     out_ready <= $urandom_range(0, 1);
          RX_MOSTLY:   out_ready <= ($urandom_range(0, 3) != 0);
          RX_PERIODIC: out_ready <= (tick % 5 != 0);
          default:     out_ready <= 1'b1;
        endcase
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(logic m, logic [KEY_IN_W-1:0] k, logic [7:0] s);
    mode     <= m;
    key_bits <= k;
    spi_byte <= s;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_word(m, k, s);
    accepted++;
    @(negedge clk);
  endtask

  task automatic pause(int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (tracker.due.size() != 0) @(negedge clk);
  endtask

  function automatic logic [KEY_IN_W-1:0] fresh_pattern();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return KEY_IN_W'(1) << $urandom_range(0, COLS - 1);
    if (pick < 65) return (KEY_IN_W'(1) << $urandom_range(0, COLS - 1)) |
                          (KEY_IN_W'(1) << $urandom_range(0, COLS - 1));
    if (pick < 82) return '0;
    if (pick < 87) return '1;
    return KEY_IN_W'($urandom);
  endfunction

  task automatic run_random(int count);
    int n, burst, gap, ticks_left;
    logic [KEY_IN_W-1:0] pattern, k;
    logic [7:0] s;
    n = 0;
    ticks_left = 0;
    pattern = '0;
    while (n < count) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && n < count) begin
        if ($urandom_range(0, 3) == 0) begin
          s = ($urandom_range(0, 2) == 0) ? SPI_NOP : 8'($urandom);
          send_word(MODE_SPI, KEY_IN_W'($urandom), s);
        end else begin
          if (ticks_left == 0) begin
            pattern = fresh_pattern();
            ticks_left = $urandom_range(1, 10);
          end
          ticks_left--;
          k = pattern;
          // occasional bounce on one column
          if ($urandom_range(0, 9) == 0) k = k ^ (KEY_IN_W'(1) << $urandom_range(0, COLS - 1));
          send_word(MODE_SCAN, k, 8'($urandom));
        end
        n++;
        burst--;
        if (n == DRAIN_AT) wait_drained();
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) pause(gap);
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    mode = MODE_SCAN;
    key_bits = '0;
    spi_byte = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // LED commands: nop, clear, set, out-of-range columns
    send_word(MODE_SPI, '0, SPI_NOP);
    send_word(MODE_SPI, '0, 8'h00);
    send_word(MODE_SPI, '0, 8'hBF);
    send_word(MODE_SPI, '0, 8'hF9);
    send_word(MODE_SPI, '0, 8'hC1);
    send_word(MODE_SPI, '0, 8'hB9);
    send_word(MODE_SPI, '0, 8'h81);
    // all keys of row 1 debounce; last column wins the held key
    repeat (3) send_word(MODE_SCAN, '1, 8'h00);
    send_word(MODE_SPI, '0, SPI_NOP);
    send_word(MODE_SPI, '0, SPI_NOP);
    repeat (3) send_word(MODE_SCAN, '0, 8'hFF);
    repeat (2) send_word(MODE_SCAN, 9'h001, 8'h00);
    // press then release before the reply is read
    repeat (3) send_word(MODE_SCAN, 9'h100, 8'h00);
    repeat (3) send_word(MODE_SCAN, '0, 8'h00);
    send_word(MODE_SPI, '0, SPI_NOP);

    run_random(RANDOM_WORDS);

    wait_drained();
    repeat (4) @(negedge clk);
    if (tracker.errors == 0 && tracker.due.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
